@@ rtl/core/ppmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmp_pkg
// Shared types and constants of the ASCII PPM pixel parser: parse phases,
// result kinds, character codes and the result record.
// ----------------------------------------------------------------------------
package ppmp_pkg;

    localparam int DIM_BITS = 16;
    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
    localparam int ACC_W = DIM_BITS + 4;
    localparam int PROD_W = 2 * DIM_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_P    = 4'd0,
        PH_3    = 4'd1,
        PH_W    = 4'd2,
        PH_H    = 4'd3,
        PH_M    = 4'd4,
        PH_R    = 4'd5,
        PH_G    = 4'd6,
        PH_B    = 4'd7,
        PH_DONE = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_SUCCESS = 2'd1,
        KIND_FAIL    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] pixel_index;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        run_last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } res_pair_t;

endpackage

@@ rtl/core/ppmp_if.sv @@
// ----------------------------------------------------------------------------
// ppmp_if
// Valid/ready channels of the parser: file bytes in, result records out.
// ----------------------------------------------------------------------------
interface ppmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface ppmp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] pixel_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        run_last;

    modport source (
        output valid, output result_kind, output blue, output green, output red,
        output pixel_index, output image_width, output image_height, output run_last,
        input ready
    );
    modport sink (
        input valid, input result_kind, input blue, input green, input red,
        input pixel_index, input image_width, input image_height, input run_last,
        output ready
    );
endinterface

@@ rtl/core/ppmp_in_reg.sv @@
// ----------------------------------------------------------------------------
// ppmp_in_reg
// Input register: captures one byte transfer and holds it until the parse
// stage takes it.
// ----------------------------------------------------------------------------
module ppmp_in_reg
    import ppmp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ppmp_byte_if.sink      byte_in,
    input  logic           take,
    output logic           item_valid,
    output item_t          item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign byte_in.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (byte_in.valid && byte_in.ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            item_reg.data_byte   <= byte_in.data_byte;
            item_reg.end_of_file <= byte_in.end_of_file;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/core/ppmp_step.sv @@
// ----------------------------------------------------------------------------
// ppmp_step
// Parser state and the per-byte step: token skipping, number accumulation,
// header and pixel commits, and up to two results per byte.
// ----------------------------------------------------------------------------
module ppmp_step
    import ppmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  item_t     item,
    output res_pair_t pair
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic                in_comment_reg;
    logic                in_comment_next;
    logic                in_number_reg;
    logic                in_number_next;
    logic [DIM_BITS-1:0] number_reg;
    logic [DIM_BITS-1:0] number_next;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] width_next;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIM_BITS-1:0] height_next;
    logic [7:0]          red_hold_reg;
    logic [7:0]          red_hold_next;
    logic [7:0]          green_hold_reg;
    logic [7:0]          green_hold_next;
    logic [31:0]         done_reg;
    logic [31:0]         done_next;
    logic [31:0]         total_reg;
    logic [31:0]         total_next;

    logic [7:0]          c;
    logic                is_digit;
    logic                is_ws;
    logic [3:0]          digit;
    logic [ACC_W-1:0]    acc;
    logic                header_phase;
    logic [DIM_BITS-1:0] acc_val;
    logic [PROD_W-1:0]   prod;
    logic [31:0]         prod_sat;
    logic [31:0]         done_inc;
    logic                sep_go;
    logic                cmt_go;
    logic                starts_num;
    logic                eof_cmt;
    logic [DIM_BITS-1:0] cmt_val;
    logic                pix_hit;
    logic                succ_hit;
    logic                fail_hit;
    res_t                pix_res;
    res_t                succ_res;
    res_t                fail_res;

    assign c        = item.data_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    assign digit    = 4'(c - CH_ZERO);

    assign acc = (ACC_W'(number_reg) << 3) + (ACC_W'(number_reg) << 1) + ACC_W'(digit);
    assign header_phase = (phase_reg == PH_W) || (phase_reg == PH_H) || (phase_reg == PH_M);
    assign acc_val = (header_phase && (acc > ACC_W'(DIM_MAX))) ? DIM_MAX
                                                               : acc[DIM_BITS-1:0];

    assign prod     = PROD_W'(width_reg) * PROD_W'(height_reg);
    assign prod_sat = (64'(prod) > 64'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(prod);
    assign done_inc = done_reg + 32'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        in_number_next  = in_number_reg;
        number_next     = number_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;
        done_next       = done_reg;
        total_next      = total_reg;
        pix_hit         = 1'b0;
        succ_hit        = 1'b0;
        fail_hit        = 1'b0;
        sep_go          = 1'b0;
        cmt_go          = 1'b0;

        if (phase_reg != PH_DONE)
        begin
            if (in_comment_reg)
            begin
                if (c == CH_LF)
                begin
                    in_comment_next = 1'b0;
                end
            end
            else if (in_number_reg && is_digit)
            begin
                number_next = acc_val;
            end
            else
            begin
                cmt_go = in_number_reg;
                sep_go = 1'b1;
            end
        end

        starts_num = !in_number_reg && is_digit && (phase_reg != PH_P) && (phase_reg != PH_3);
        eof_cmt = item.end_of_file && (phase_reg != PH_DONE) && !in_comment_reg &&
                  ((in_number_reg && is_digit) || (sep_go && starts_num));
        if (eof_cmt)
        begin
            cmt_val = in_number_reg ? acc_val : DIM_BITS'(digit);
        end
        else
        begin
            cmt_val = number_reg;
        end

        if (cmt_go || eof_cmt)
        begin
            in_number_next = 1'b0;
            number_next    = '0;
            unique case (phase_reg)
                PH_W:
                begin
                    width_next = cmt_val;
                    phase_next = PH_H;
                end
                PH_H:
                begin
                    height_next = cmt_val;
                    phase_next  = PH_M;
                end
                PH_M:
                begin
                    total_next = prod_sat;
                    done_next  = '0;
                    if ((width_reg == '0) || (height_reg == '0))
                    begin
                        succ_hit   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_R;
                    end
                end
                PH_R:
                begin
                    red_hold_next = cmt_val[7:0];
                    phase_next    = PH_G;
                end
                PH_G:
                begin
                    green_hold_next = cmt_val[7:0];
                    phase_next      = PH_B;
                end
                PH_B:
                begin
                    pix_hit   = 1'b1;
                    done_next = done_inc;
                    if (done_inc == total_reg)
                    begin
                        succ_hit   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_R;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (sep_go && (phase_next != PH_DONE))
        begin
            priority if (phase_next == PH_3)
            begin
                if (c == CH_3)
                begin
                    phase_next = PH_W;
                end
                else
                begin
                    fail_hit   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            else if (is_ws)
            begin
            end
            else if (c == CH_HASH)
            begin
                in_comment_next = 1'b1;
            end
            else if (phase_next == PH_P)
            begin
                if (c == CH_P)
                begin
                    phase_next = PH_3;
                end
                else
                begin
                    fail_hit   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            else if (is_digit)
            begin
                in_number_next = 1'b1;
                number_next    = DIM_BITS'(digit);
            end
            else
            begin
                fail_hit   = 1'b1;
                phase_next = PH_DONE;
            end
        end

        if (item.end_of_file)
        begin
            if (phase_next != PH_DONE)
            begin
                fail_hit = 1'b1;
            end
            phase_next      = PH_P;
            in_comment_next = 1'b0;
            in_number_next  = 1'b0;
            number_next     = '0;
            width_next      = '0;
            height_next     = '0;
            red_hold_next   = '0;
            green_hold_next = '0;
            done_next       = '0;
            total_next      = '0;
        end
    end

    always_comb
    begin
        pix_res             = '0;
        pix_res.result_kind = KIND_PIXEL;
        pix_res.blue        = cmt_val[7:0];
        pix_res.green       = green_hold_reg;
        pix_res.red         = red_hold_reg;
        pix_res.pixel_index = done_reg;

        succ_res              = '0;
        succ_res.result_kind  = KIND_SUCCESS;
        succ_res.image_width  = 16'(width_reg);
        succ_res.image_height = 16'(height_reg);

        fail_res             = '0;
        fail_res.result_kind = KIND_FAIL;

        pair.count  = 2'(pix_hit) + 2'(succ_hit) + 2'(fail_hit);
        if (pix_hit)
        begin
            pair.first  = pix_res;
            pair.second = succ_hit ? succ_res : fail_res;
        end
        else
        begin
            pair.first  = succ_hit ? succ_res : fail_res;
            pair.second = fail_res;
        end
        pair.first.run_last  = (pair.count == 2'd1);
        pair.second.run_last = 1'b1;
        if (!fire)
        begin
            pair.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_P;
            in_comment_reg <= 1'b0;
            in_number_reg  <= 1'b0;
            number_reg     <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            red_hold_reg   <= '0;
            green_hold_reg <= '0;
            done_reg       <= '0;
            total_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            in_number_reg  <= in_number_next;
            number_reg     <= number_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            red_hold_reg   <= red_hold_next;
            green_hold_reg <= green_hold_next;
            done_reg       <= done_next;
            total_reg      <= total_next;
        end
    end

    // The end of a file always returns the parser to its start phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.end_of_file) |=> (phase_reg == PH_P && !in_number_reg))
        else $error("parser did not restart after end of file");

    // Once an outcome is reported, bytes up to the end of file give no results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (pair.count == 2'd0))
        else $error("result produced after the outcome");

endmodule

@@ rtl/core/ppmp_res_fifo.sv @@
// ----------------------------------------------------------------------------
// ppmp_res_fifo
// Result buffer: takes up to two results per cycle from the parse stage and
// presents one result per cycle to the output channel.
// ----------------------------------------------------------------------------
module ppmp_res_fifo
    import ppmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_pair_t pair,
    input  logic      pop,
    output logic      space_ok,
    output logic      head_valid,
    output res_t      head
);

    res_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus;

    assign space_ok    = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign head_valid  = count_reg != '0;
    assign head        = mem[rd_ptr_reg];
    assign wr_ptr_plus = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(pair.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(pair.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= pair.first;
        end
        if (pair.count == 2'd2)
        begin
            mem[wr_ptr_plus] <= pair.second;
        end
    end

    // Results are only written when two free entries are guaranteed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.count != 2'd0) |-> (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("result buffer written without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result buffer read while empty");

endmodule

@@ rtl/core/ppm_ascii_pixel_parser_core.sv @@
// ----------------------------------------------------------------------------
// ppm_ascii_pixel_parser_core
// Byte-serial parser for ASCII PPM images that emits one result per pixel
// and a final success or failure record.
// ----------------------------------------------------------------------------
// A byte is held in the input register until the result buffer has room; its
// results are then written to that buffer. Throughput: one byte per cycle
// while each byte gives at most one result and the output channel is ready;
// the output channel moves one result per cycle, which sets the pace when a
// byte gives two. Reset clears the parse state and empties the result buffer.
module ppm_ascii_pixel_parser_core
    import ppmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppmp_byte_if.sink   byte_in,
    ppmp_res_if.source  result_out
);

    logic      item_valid;
    item_t     item;
    logic      space_ok;
    logic      take;
    res_pair_t pair;
    logic      head_valid;
    res_t      head;
    logic      pop;

    assign take = item_valid && space_ok;
    assign pop  = result_out.valid && result_out.ready;

    ppmp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ppmp_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (take),
        .item  (item),
        .pair  (pair)
    );

    ppmp_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head)
    );

    assign result_out.valid        = head_valid;
    assign result_out.result_kind  = head.result_kind;
    assign result_out.blue         = head.blue;
    assign result_out.green        = head.green;
    assign result_out.red          = head.red;
    assign result_out.pixel_index  = head.pixel_index;
    assign result_out.image_width  = head.image_width;
    assign result_out.image_height = head.image_height;
    assign result_out.run_last     = head.run_last;

endmodule

@@ test/ppm_ascii_pixel_parser_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppm_ascii_pixel_parser_core_test
// Self-checking bench for the ASCII PPM parser. Generated P3 files, some
// clean and some damaged, stream into the byte channel in random bursts
// while the result channel stalls on shifting patterns. A scoreboard keeps
// its own model of the parse and checks every result transfer in order.
// ----------------------------------------------------------------------------
import ppmp_pkg::*;

class pixel_stream_scoreboard;
    phase_t      stage;
    bit          in_cmt;
    bit          in_num;
    logic [15:0] acc;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [7:0]  red_h;
    logic [7:0]  grn_h;
    logic [31:0] px_done;
    logic [31:0] px_total;
    res_t        pending_results[$];
    int          errors;
    int          checked;

    function new();
        errors = 0;
        checked = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        stage = PH_P;
        in_cmt = 1'b0;
        in_num = 1'b0;
        acc = '0;
        wid = '0;
        hgt = '0;
        red_h = '0;
        grn_h = '0;
        px_done = '0;
        px_total = '0;
    endfunction

    function void add_result(kind_t kind, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic [31:0] idx, logic [15:0] w, logic [15:0] h);
        res_t rec;
        rec.result_kind = kind;
        rec.blue = b;
        rec.green = g;
        rec.red = r;
        rec.pixel_index = idx;
        rec.image_width = w;
        rec.image_height = h;
        rec.run_last = 1'b0;
        pending_results.push_back(rec);
    endfunction

    function void finish_fail();
        stage = PH_DONE;
        add_result(KIND_FAIL, '0, '0, '0, '0, '0, '0);
    endfunction

    function void finish_ok();
        stage = PH_DONE;
        add_result(KIND_SUCCESS, '0, '0, '0, '0, wid, hgt);
    endfunction

    function void commit_number();
        logic [15:0] v;
        logic [63:0] prod;
        v = acc;
        in_num = 1'b0;
        acc = '0;
        case (stage)
            PH_W:
            begin
                wid = v;
                stage = PH_H;
            end
            PH_H:
            begin
                hgt = v;
                stage = PH_M;
            end
            PH_M:
            begin
                prod = {48'd0, wid} * {48'd0, hgt};
                px_total = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                px_done = '0;
                if (px_total == 32'd0)
                    finish_ok();
                else
                    stage = PH_R;
            end
            PH_R:
            begin
                red_h = v[7:0];
                stage = PH_G;
            end
            PH_G:
            begin
                grn_h = v[7:0];
                stage = PH_B;
            end
            PH_B:
            begin
                add_result(KIND_PIXEL, v[7:0], grn_h, red_h, px_done, '0, '0);
                px_done = px_done + 32'd1;
                if (px_done == px_total)
                    finish_ok();
                else
                    stage = PH_R;
            end
            default:
            begin
            end
        endcase
    endfunction

    function void take_separator(logic [7:0] c);
        if (stage == PH_3)
        begin
            if (c == CH_3)
                stage = PH_W;
            else
                finish_fail();
        end
        else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
        begin
        end
        else if (c == CH_HASH)
            in_cmt = 1'b1;
        else if (stage == PH_P)
        begin
            if (c == CH_P)
                stage = PH_3;
            else
                finish_fail();
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            in_num = 1'b1;
            acc = {8'd0, c - CH_ZERO};
        end
        else
            finish_fail();
    endfunction

    function void accept_byte(logic [7:0] c, logic eof);
        int          first;
        logic [31:0] grown;
        first = pending_results.size();
        if (stage != PH_DONE)
        begin
            if (in_cmt)
            begin
                if (c == CH_LF)
                    in_cmt = 1'b0;
            end
            else if (in_num && c >= CH_ZERO && c <= CH_NINE)
            begin
                grown = {16'd0, acc} * 32'd10 + {24'd0, c - CH_ZERO};
                if (stage <= PH_M)
                    acc = (grown > {16'd0, DIM_MAX}) ? DIM_MAX : grown[15:0];
                else
                    acc = grown[15:0];
            end
            else
            begin
                if (in_num)
                    commit_number();
                if (stage != PH_DONE)
                    take_separator(c);
            end
        end
        if (eof)
        begin
            if (stage != PH_DONE && in_num)
                commit_number();
            if (stage != PH_DONE)
                finish_fail();
            clear_parse();
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].run_last = 1'b1;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d field %s: got %0h, expected %0h",
                             checked, name, got, want));
    endtask

    task check_result(res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result of kind %0d arrived with none expected",
                             got.result_kind));
            return;
        end
        want = pending_results.pop_front();
        compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        compare_field("blue", 32'(got.blue), 32'(want.blue));
        compare_field("green", 32'(got.green), 32'(want.green));
        compare_field("red", 32'(got.red), 32'(want.red));
        compare_field("pixel_index", got.pixel_index, want.pixel_index);
        compare_field("image_width", 32'(got.image_width), 32'(want.image_width));
        compare_field("image_height", 32'(got.image_height), 32'(want.image_height));
        compare_field("run_last", 32'(got.run_last), 32'(want.run_last));
        checked++;
    endtask
endclass

module ppm_ascii_pixel_parser_core_test;

    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_BYTES = 1000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_STARVED
    } rx_mode_t;

    logic clk;
    logic rst_n;

    ppmp_byte_if byte_ch();
    ppmp_res_if  res_ch();

    ppm_ascii_pixel_parser_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (res_ch)
    );

    pixel_stream_scoreboard sb = new();

    logic [7:0] text[$];
    int         burst_left = 0;
    int         cycle_count = 0;
    bit         draining = 1'b0;
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_left = 0;
    int         rx_period = 2;
    int         rx_tick = 0;
    logic       rx_take;
    res_t       seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.result_kind = kind_t'(res_ch.result_kind);
            seen.blue = res_ch.blue;
            seen.green = res_ch.green;
            seen.red = res_ch.red;
            seen.pixel_index = res_ch.pixel_index;
            seen.image_width = res_ch.image_width;
            seen.image_height = res_ch.image_height;
            seen.run_last = res_ch.run_last;
            sb.check_result(seen);
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
            rx_period = $urandom_range(2, 5);
        end
        rx_left = rx_left - 1;
        rx_tick = rx_tick + 1;
        case (rx_mode)
            RX_OPEN:     rx_take = 1'b1;
            RX_COIN:     rx_take = 1'($urandom_range(0, 1));
            RX_PERIODIC: rx_take = (rx_tick % rx_period) == 0;
            default:     rx_take = $urandom_range(0, 15) == 0;
        endcase
        if (draining)
            rx_take = 1'b1;
        res_ch.ready <= rx_take;
    end

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    function automatic void put_number(int v);
        int zeros;
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) text.push_back(CH_ZERO);
        put_text($sformatf("%0d", v));
    endfunction

    function automatic void put_blank();
        int         n;
        int         body;
        logic [7:0] c;
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 5) == 0)
        begin
            text.push_back(CH_HASH);
            body = $urandom_range(0, 6);
            repeat (body)
            begin
                c = 8'($urandom_range(0, 255));
                text.push_back((c == CH_LF) ? CH_SPACE : c);
            end
            text.push_back(CH_LF);
            n = $urandom_range(0, 2);
        end
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: text.push_back(CH_SPACE);
                1: text.push_back(CH_TAB);
                2: text.push_back(CH_CR);
                default: text.push_back(CH_LF);
            endcase
        end
    endfunction

    function automatic void build_file();
        int w;
        int h;
        int cells;
        int fault;
        int n;
        text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 16);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        fault = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 2) == 0)
            put_blank();
        put_text("P3");
        if ($urandom_range(0, 2) != 0)
            put_blank();
        if ($urandom_range(0, 9) == 0)
        begin
            w = $urandom_range(65000, 2000000);
            h = 0;
            if ($urandom_range(0, 1) == 0)
            begin
                h = w;
                w = 0;
            end
        end
        else
        begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        end
        put_number(w);
        put_blank();
        put_number(h);
        put_blank();
        put_number(($urandom_range(0, 4) == 0) ? $urandom_range(0, 100000) : 255);
        cells = w * h * 3;
        for (int i = 0; i < cells; i++)
        begin
            put_blank();
            put_number(($urandom_range(0, 9) == 0) ? $urandom_range(256, 999999)
                                                   : $urandom_range(0, 255));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            put_blank();
            n = $urandom_range(0, 4);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end
        case (fault)
            1:
            begin
                n = $urandom_range(1, text.size());
                while (text.size() > n)
                    void'(text.pop_back());
            end
            2: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            3: text.insert($urandom_range(0, text.size() - 1), 8'($urandom_range(0, 255)));
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.end_of_file <= eof;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.accept_byte(d, eof);
        burst_left--;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        int random_sent;
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= 8'd0;
        byte_ch.end_of_file <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text.delete();
        put_text("P3 0 5 1");
        send_text();
        text.delete();
        text.push_back(8'h00);
        text.push_back(8'hFF);
        send_text();
        text.delete();
        put_text("#\nP31 1 9 300 7 511 Z");
        send_text();

        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            build_file();
            random_sent += text.size();
            send_text();
        end
        byte_ch.valid <= 1'b0;
        draining <= 1'b1;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ppmp_pkg.sv
rtl/core/ppmp_if.sv
rtl/core/ppmp_in_reg.sv
rtl/core/ppmp_step.sv
rtl/core/ppmp_res_fifo.sv
rtl/core/ppm_ascii_pixel_parser_core.sv
test/ppm_ascii_pixel_parser_core_test.sv
